// ===== rtl/sam_pkg.sv =====
// Shared types, constants and address-translation helpers for the address multiplexer.
package sam_pkg;

  // Default CPU rate divisors in oscillator cycles
  localparam int unsigned FAST_DIVISOR_DEF = 8;
  localparam int unsigned SLOW_DIVISOR_DEF = 16;

  // Item kinds
  typedef enum logic [2:0] {
    REQ_CPU   = 3'd0,
    REQ_VIDEO = 3'd1,
    REQ_HSYNC = 3'd2,
    REQ_FSYNC = 3'd3,
    REQ_LOAD  = 3'd4
  } sam_req_e;

  // Device select codes
  typedef enum logic [2:0] {
    SEL_RAM  = 3'd0,
    SEL_ROM0 = 3'd1,
    SEL_ROM1 = 3'd2,
    SEL_CART = 3'd3,
    SEL_IO0  = 3'd4,
    SEL_IO1  = 3'd5,
    SEL_IO2  = 3'd6,
    SEL_SYS  = 3'd7
  } sam_sel_e;

  // Address map boundaries
  localparam logic [15:0] ADDR_ROM0    = 16'h8000;
  localparam logic [15:0] ADDR_ROM1    = 16'hA000;
  localparam logic [15:0] ADDR_CART    = 16'hC000;
  localparam logic [15:0] ADDR_IO0     = 16'hFF00;
  localparam logic [15:0] ADDR_IO1     = 16'hFF20;
  localparam logic [15:0] ADDR_IO2     = 16'hFF40;
  localparam logic [15:0] ADDR_SYS     = 16'hFF60;
  localparam logic [15:0] ADDR_CTRL_WR = 16'hFFC0;
  localparam logic [15:0] ADDR_VECTOR  = 16'hFFE0;

  // Control register base field mask and RAS fill value
  localparam logic [15:0] BASE_MASK = 16'h03F8;
  localparam logic [15:0] RAS_FILL  = 16'h8080;

  // Row and column translation per memory size
  localparam logic [15:0] ROW_MASK  [4] = '{16'h007F, 16'h007F, 16'h00FF, 16'h00FF};
  localparam logic [1:0]  COL_SHIFT [4] = '{2'd2, 2'd1, 2'd0, 2'd0};
  localparam logic [15:0] COL_MASK  [4] = '{16'h3F00, 16'h7F00, 16'hFF00, 16'hFF00};
  localparam logic [15:0] RAS_BIT   [4] = '{16'h1000, 16'h4000, 16'h0000, 16'h0000};

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] cpu_address;
    logic        read_not_write;
    logic [7:0]  bytes_wanted;
    logic [15:0] load_value;
  } sam_req_t;

  typedef struct packed {
    logic [2:0]  device_select;
    logic [15:0] ram_address;
    logic        is_ram;
    logic [5:0]  cpu_cycles;
    logic [15:0] video_address;
    logic        video_valid;
    logic [7:0]  bytes_granted;
    logic [15:0] control_value;
  } sam_rsp_t;

  // CPU access decode result
  typedef struct packed {
    logic [2:0]  sel;
    logic [15:0] ram_addr;
    logic        is_ram;
    logic [5:0]  cycles;
    logic [15:0] ctrl_next;
    logic        rate_next;
  } sam_cpu_t;

  // Video counter result
  typedef struct packed {
    logic [15:0] vaddr;
    logic        vvalid;
    logic [7:0]  granted;
    logic [15:0] vc_next;
    logic [1:0]  x_next;
    logic [3:0]  y_next;
  } sam_vid_t;

  // Translate a CPU or video address into a multiplexed RAM address
  function automatic logic [15:0] mux_addr(input logic [15:0] a, input logic [1:0] sz);
    logic [15:0] z;
    z = ((a << COL_SHIFT[sz]) & COL_MASK[sz]) | (a & ROW_MASK[sz]);
    if (!sz[1] && ((a & RAS_BIT[sz]) == 16'h0000)) begin
      z = z | RAS_FILL;
    end
    return z;
  endfunction

  function automatic logic [1:0] x_div(input logic [2:0] mode);
    logic [1:0] d;
    case (mode)
      3'd1:    d = 2'd3;
      3'd3:    d = 2'd2;
      default: d = 2'd1;
    endcase
    return d;
  endfunction

  function automatic logic [3:0] y_div(input logic [2:0] mode);
    logic [3:0] d;
    case (mode)
      3'd0:    d = 4'd12;
      3'd2:    d = 4'd3;
      3'd4:    d = 4'd2;
      default: d = 4'd1;
    endcase
    return d;
  endfunction

  function automatic logic [4:0] hs_add(input logic [2:0] mode);
    logic [4:0] n;
    case (mode)
      3'd1, 3'd3, 3'd5: n = 5'd8;
      3'd7:             n = 5'd0;
      default:          n = 5'd16;
    endcase
    return n;
  endfunction

  function automatic logic [15:0] hs_keep(input logic [2:0] mode);
    logic [15:0] k;
    case (mode)
      3'd1, 3'd3, 3'd5: k = 16'hFFF1;
      3'd7:             k = 16'hFFFF;
      default:          k = 16'hFFE1;
    endcase
    return k;
  endfunction

  // Small remainder for the X divider (value up to 4, divisor 1..3)
  function automatic logic [1:0] x_mod(input logic [2:0] v, input logic [1:0] d);
    logic [1:0] r;
    case (d)
      2'd2:    r = {1'b0, v[0]};
      2'd3: begin
        if (v == 3'd3) r = 2'd0;
        else if (v == 3'd4) r = 2'd1;
        else r = v[1:0];
      end
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  // Small remainder for the Y divider (value up to 16, divisor 1, 2, 3 or 12)
  function automatic logic [3:0] y_mod(input logic [4:0] v, input logic [3:0] d);
    logic [4:0] t;
    logic [3:0] r;
    t = v;
    case (d)
      4'd12: begin
        if (t >= 5'd12) t = t - 5'd12;
        r = t[3:0];
      end
      4'd3: begin
        if (t >= 5'd12) t = t - 5'd12;
        if (t >= 5'd6) t = t - 5'd6;
        if (t >= 5'd3) t = t - 5'd3;
        r = t[3:0];
      end
      4'd2:    r = {3'b000, t[0]};
      default: r = 4'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/sam_req_if.sv =====
// Request channel interface: valid, ready and one request word.
interface sam_req_if
  import sam_pkg::*;
();
  logic     valid;
  logic     ready;
  sam_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/sam_rsp_if.sv =====
// Result channel interface: valid, ready and one result word.
interface sam_rsp_if
  import sam_pkg::*;
();
  logic     valid;
  logic     ready;
  sam_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/sam_cpu_decode.sv =====
// CPU access decoder: device select, RAM address, control bit writes and cycle timing.
module sam_cpu_decode
  import sam_pkg::*;
#(
  parameter int unsigned FAST_DIVISOR = FAST_DIVISOR_DEF,
  parameter int unsigned SLOW_DIVISOR = SLOW_DIVISOR_DEF
) (
  input  logic [15:0] ctrl_i,
  input  logic        rate_fast_i,
  input  logic [15:0] addr_i,
  input  logic        rd_i,
  output sam_cpu_t    res_o
);

  localparam logic [5:0] FAST_CYC     = 6'(FAST_DIVISOR);
  localparam logic [5:0] SLOW_CYC     = 6'(SLOW_DIVISOR);
  localparam logic [5:0] TO_FAST_PEN  = 6'(2 * (FAST_DIVISOR / 2));
  localparam logic [5:0] TO_SLOW_PEN  = 6'(FAST_DIVISOR / 2);

  logic        map1;
  logic        fast;
  logic        ad;
  logic        in_ram;
  logic        fc;
  logic [15:0] bit_sel;
  logic [5:0]  base_cyc;

  assign map1 = ctrl_i[15];
  assign fast = ctrl_i[12];
  assign ad   = !map1 && ctrl_i[11];
  assign in_ram = (addr_i < ADDR_ROM0) || (map1 && (addr_i < ADDR_IO0));
  assign bit_sel = 16'h0001 << addr_i[4:1];

  // Decode select, translate address, apply control bit writes
  always_comb begin
    res_o.ram_addr  = 16'h0000;
    res_o.is_ram    = 1'b0;
    res_o.ctrl_next = ctrl_i;
    fc = fast || ad;
    if (in_ram) begin
      res_o.ram_addr = mux_addr(addr_i, ctrl_i[14:13]);
      if (ctrl_i[14]) begin
        res_o.ram_addr[15] = res_o.ram_addr[15] | ctrl_i[10];
      end
      res_o.is_ram = 1'b1;
      fc = fast;
    end

    if (addr_i < ADDR_ROM0) begin
      res_o.sel = rd_i ? SEL_RAM : SEL_SYS;
    end else if (map1 && rd_i && (addr_i < ADDR_IO0)) begin
      res_o.sel = SEL_RAM;
    end else if (addr_i < ADDR_ROM1) begin
      res_o.sel = SEL_ROM0;
    end else if (addr_i < ADDR_CART) begin
      res_o.sel = SEL_ROM1;
    end else if (addr_i < ADDR_IO0) begin
      res_o.sel = SEL_CART;
    end else if (addr_i < ADDR_IO1) begin
      res_o.sel = SEL_IO0;
      fc = fast;
    end else if (addr_i < ADDR_IO2) begin
      res_o.sel = SEL_IO1;
    end else if (addr_i < ADDR_SYS) begin
      res_o.sel = SEL_IO2;
    end else if (addr_i < ADDR_VECTOR) begin
      res_o.sel = SEL_SYS;
      if (!rd_i && (addr_i >= ADDR_CTRL_WR)) begin
        if (addr_i[0]) res_o.ctrl_next = ctrl_i | bit_sel;
        else res_o.ctrl_next = ctrl_i & ~bit_sel;
      end
    end else begin
      res_o.sel = SEL_ROM1;
    end
  end

  // Time the access, adding a penalty when the rate switches
  always_comb begin
    base_cyc = fc ? FAST_CYC : SLOW_CYC;
    res_o.rate_next = fc;
    if (fc != rate_fast_i) begin
      res_o.cycles = base_cyc + (fc ? TO_FAST_PEN : TO_SLOW_PEN);
    end else begin
      res_o.cycles = base_cyc;
    end
  end

endmodule

// ===== rtl/sam_video_counter.sv =====
// Video address counter: fetch grant, X/Y divide logic and horizontal sync step.
module sam_video_counter
  import sam_pkg::*;
(
  input  logic [15:0] ctrl_i,
  input  logic [15:0] vc_i,
  input  logic [1:0]  x_i,
  input  logic [3:0]  y_i,
  input  logic [7:0]  want_i,
  input  logic        hsync_i,
  output sam_vid_t    res_o
);

  logic [2:0]  mode;
  logic [3:0]  low;
  logic [8:0]  run_end;
  logic        short_run;
  logic [4:0]  got;
  logic [4:0]  step;
  logic [15:0] nb;
  logic [15:0] diff;
  logic [1:0]  x_adv;
  logic [3:0]  y_adv;
  logic [15:0] adv_vc;
  logic [1:0]  adv_x;
  logic [3:0]  adv_y;

  assign mode      = ctrl_i[2:0];
  assign low       = vc_i[3:0];
  assign run_end   = {5'b00000, low} + {1'b0, want_i};
  assign short_run = run_end < 9'd16;
  assign got       = 5'd16 - {1'b0, low};
  assign step      = hsync_i ? hs_add(mode) : got;
  assign nb        = vc_i + {11'b0, step};
  assign diff      = vc_i ^ nb;
  assign x_adv     = x_mod({1'b0, x_i} + 3'd1, x_div(mode));
  assign y_adv     = y_mod({1'b0, y_i} + 5'd1, y_div(mode));

  // Advance the counter, holding back where the dividers break the run
  always_comb begin
    adv_vc = nb;
    adv_x  = x_i;
    adv_y  = y_i;
    if (diff[4]) begin
      adv_x = x_adv;
      if (x_adv != 2'd0) begin
        adv_vc = nb - 16'h0010;
      end else if (diff[5]) begin
        adv_y = y_adv;
        if (y_adv != 4'd0) begin
          adv_vc = nb - 16'h0020;
        end
      end
    end
  end

  // Select fetch or sync result
  always_comb begin
    res_o.vvalid = !ctrl_i[12];
    res_o.vaddr  = ctrl_i[12] ? 16'h0000 : mux_addr(vc_i, ctrl_i[14:13]);
    if (hsync_i) begin
      res_o.vc_next = adv_vc & hs_keep(mode);
      res_o.x_next  = adv_x;
      res_o.y_next  = adv_y;
      res_o.granted = 8'd0;
    end else if (short_run) begin
      res_o.vc_next = vc_i + {8'b0, want_i};
      res_o.x_next  = x_i;
      res_o.y_next  = y_i;
      res_o.granted = want_i;
    end else begin
      res_o.vc_next = adv_vc;
      res_o.x_next  = adv_x;
      res_o.y_next  = adv_y;
      res_o.granted = {3'b000, got};
    end
  end

endmodule

// ===== rtl/sam_address_multiplexer.sv =====
// Top level of the address multiplexer and video address counter.
//
//   channel  dir  word       content
//   req_i    in   sam_req_t  cpu access, video fetch, hsync, fsync or register load
//   rsp_o    out  sam_rsp_t  select, RAM/video address, timing, grant, control value
//
// One word is accepted per cycle; its result sits in the output register the
// cycle after acceptance. All decode and counter update is one level of logic
// between the state registers and the output register. req_i.ready drops only
// while the output register is full and rsp_o is stalled. Reset clears the
// control register, the video counter, both dividers, the rate flag and rsp valid.
module sam_address_multiplexer
  import sam_pkg::*;
#(
  parameter int unsigned FAST_DIVISOR = FAST_DIVISOR_DEF,
  parameter int unsigned SLOW_DIVISOR = SLOW_DIVISOR_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sam_req_if.sink   req_i,
  sam_rsp_if.source rsp_o
);

  logic [15:0] ctrl_q, ctrl_d;
  logic [15:0] vc_q, vc_d;
  logic [1:0]  x_q, x_d;
  logic [3:0]  y_q, y_d;
  logic        rate_q, rate_d;
  logic        rsp_vld_q, rsp_vld_d;
  sam_rsp_t    rsp_q, rsp_d;
  logic        accept;
  sam_cpu_t    cpu;
  sam_vid_t    vid;

  assign req_i.ready = !rsp_vld_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign rsp_o.valid = rsp_vld_q;
  assign rsp_o.data  = rsp_q;

  sam_cpu_decode #(
    .FAST_DIVISOR (FAST_DIVISOR),
    .SLOW_DIVISOR (SLOW_DIVISOR)
  ) u_cpu (
    .ctrl_i      (ctrl_q),
    .rate_fast_i (rate_q),
    .addr_i      (req_i.data.cpu_address),
    .rd_i        (req_i.data.read_not_write),
    .res_o       (cpu)
  );

  sam_video_counter u_vid (
    .ctrl_i  (ctrl_q),
    .vc_i    (vc_q),
    .x_i     (x_q),
    .y_i     (y_q),
    .want_i  (req_i.data.bytes_wanted),
    .hsync_i (req_i.data.req_type == REQ_HSYNC),
    .res_o   (vid)
  );

  // Commit state and build the result word for the accepted item
  always_comb begin
    ctrl_d    = ctrl_q;
    vc_d      = vc_q;
    x_d       = x_q;
    y_d       = y_q;
    rate_d    = rate_q;
    rsp_vld_d = rsp_vld_q;
    rsp_d     = rsp_q;
    if (rsp_vld_q && rsp_o.ready) begin
      rsp_vld_d = 1'b0;
    end
    if (accept) begin
      rsp_vld_d = 1'b1;
      rsp_d     = '0;
      case (req_i.data.req_type)
        REQ_CPU: begin
          ctrl_d              = cpu.ctrl_next;
          rate_d              = cpu.rate_next;
          rsp_d.device_select = cpu.sel;
          rsp_d.ram_address   = cpu.ram_addr;
          rsp_d.is_ram        = cpu.is_ram;
          rsp_d.cpu_cycles    = cpu.cycles;
        end
        REQ_VIDEO: begin
          vc_d                = vid.vc_next;
          x_d                 = vid.x_next;
          y_d                 = vid.y_next;
          rsp_d.video_address = vid.vaddr;
          rsp_d.video_valid   = vid.vvalid;
          rsp_d.bytes_granted = vid.granted;
        end
        REQ_HSYNC: begin
          vc_d = vid.vc_next;
          x_d  = vid.x_next;
          y_d  = vid.y_next;
        end
        REQ_FSYNC: begin
          vc_d = (ctrl_q & BASE_MASK) << 6;
          x_d  = 2'd0;
          y_d  = 4'd0;
        end
        REQ_LOAD: begin
          ctrl_d = req_i.data.load_value;
        end
        default: begin
        end
      endcase
      rsp_d.control_value = ctrl_d;
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q    <= 16'h0000;
      vc_q      <= 16'h0000;
      x_q       <= 2'd0;
      y_q       <= 4'd0;
      rate_q    <= 1'b0;
      rsp_vld_q <= 1'b0;
    end else begin
      ctrl_q    <= ctrl_d;
      vc_q      <= vc_d;
      x_q       <= x_d;
      y_q       <= y_d;
      rate_q    <= rate_d;
      rsp_vld_q <= rsp_vld_d;
    end
  end

  // Hold the result word
  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

endmodule

// ===== bench/tb_sam_address_multiplexer.sv =====
// Self-checking bench for the address multiplexer: directed and random words, in-bench model.
module tb_sam_address_multiplexer;
  import sam_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_PERIOD   = 8;
  localparam int unsigned RESET_CYCLES = 9;
  localparam int unsigned FAST_DIV     = 8;
  localparam int unsigned SLOW_DIV     = 16;
  localparam int unsigned RANDOM_WORDS = 600;
  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 8;

  // Item kinds the block ignores
  localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
  localparam logic [2:0] KIND_UNUSED_HI = 3'd7;

  // Divide chain and hsync behavior per video mode
  localparam int unsigned XDIV_BY_MODE    [8] = '{1, 3, 1, 2, 1, 1, 1, 1};
  localparam int unsigned YDIV_BY_MODE    [8] = '{12, 1, 3, 1, 2, 1, 1, 1};
  localparam int unsigned HS_STEP_BY_MODE [8] = '{16, 8, 16, 8, 16, 8, 16, 0};
  localparam logic [15:0] HS_MASK_BY_MODE [8] = '{16'hFFE1, 16'hFFF1, 16'hFFE1, 16'hFFF1,
                                                   16'hFFE1, 16'hFFF1, 16'hFFE1, 16'hFFFF};
  // Row/column split per memory size
  localparam logic [15:0] ROW_BITS_BY_SIZE  [4] = '{16'h007F, 16'h007F, 16'h00FF, 16'h00FF};
  localparam int unsigned COL_SHL_BY_SIZE   [4] = '{2, 1, 0, 0};
  localparam logic [15:0] COL_BITS_BY_SIZE  [4] = '{16'h3F00, 16'h7F00, 16'hFF00, 16'hFF00};
  localparam logic [15:0] RAS_SENSE_BY_SIZE [4] = '{16'h1000, 16'h4000, 16'h0000, 16'h0000};

  logic clk_i = 1'b0;
  logic rst_ni;

  sam_req_if req_bus ();
  sam_rsp_if rsp_bus ();

  sam_address_multiplexer #(
    .FAST_DIVISOR(FAST_DIV),
    .SLOW_DIVISOR(SLOW_DIV)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Mirror of the block's state
  logic [15:0] ctrl_reg  = '0;
  logic [15:0] vid_count = '0;
  int unsigned xdiv_cnt  = 0;
  int unsigned ydiv_cnt  = 0;
  logic        rate_fast = 1'b0;

  sam_req_t    req_backlog[$];
  sam_rsp_t    result_words_due[$];
  int unsigned kind_tally[8];
  int unsigned counted_words = 0;
  int unsigned words_in = 0;
  int unsigned words_out = 0;
  int unsigned mismatches = 0;
  int unsigned send_gap = 0;
  int unsigned send_calm = 0;
  int unsigned stall_left = 0;
  int unsigned recv_calm = 0;
  int unsigned quiet_cycles = 0;

  // Split an address into row and column bits for the current memory size
  function automatic logic [15:0] dram_addr(input logic [15:0] a, input logic [1:0] sz);
    logic [15:0] z;
    z = ((a << COL_SHL_BY_SIZE[sz]) & COL_BITS_BY_SIZE[sz]) | (a & ROW_BITS_BY_SIZE[sz]);
    if (!sz[1] && ((a & RAS_SENSE_BY_SIZE[sz]) == 16'h0000)) z = z | 16'h8080;
    return z;
  endfunction

  // Step the video counter, folding rows back while the X/Y dividers count
  function automatic void advance_video(input int unsigned n);
    logic [15:0] nb;
    logic [15:0] diff;
    int unsigned mode;
    mode = 32'(ctrl_reg[2:0]);
    nb = vid_count + 16'(n);
    diff = vid_count ^ nb;
    if (diff[4]) begin
      xdiv_cnt = (xdiv_cnt + 1) % XDIV_BY_MODE[mode];
      if (xdiv_cnt != 0) begin
        nb = nb - 16'h0010;
      end else if (diff[5]) begin
        ydiv_cnt = (ydiv_cnt + 1) % YDIV_BY_MODE[mode];
        if (ydiv_cnt != 0) nb = nb - 16'h0020;
      end
    end
    vid_count = nb;
  endfunction

  // Result of one request word; updates the mirrored state
  function automatic sam_rsp_t sam_result(input sam_req_t w);
    sam_rsp_t    r;
    sam_sel_e    sel;
    logic [15:0] a;
    logic [15:0] z;
    logic [15:0] bitm;
    logic        rd;
    logic        map1;
    logic        fast;
    logic        ad;
    logic        fc;
    int unsigned cyc;
    int unsigned low;
    int unsigned got;
    int unsigned mode;
    r = '0;
    case (w.req_type)
      REQ_CPU: begin
        a = w.cpu_address;
        rd = w.read_not_write;
        map1 = ctrl_reg[15];
        fast = ctrl_reg[12];
        ad = !map1 && ctrl_reg[11];
        if (a < ADDR_ROM0 || (map1 && a < ADDR_IO0)) begin
          z = dram_addr(a, ctrl_reg[14:13]);
          if (ctrl_reg[14]) z = z | {ctrl_reg[10], 15'h0000};
          r.ram_address = z;
          r.is_ram = 1'b1;
          fc = fast;
        end else begin
          fc = fast || ad;
        end
        if (a < ADDR_ROM0) begin
          sel = rd ? SEL_RAM : SEL_SYS;
        end else if (map1 && rd && a < ADDR_IO0) begin
          sel = SEL_RAM;
        end else if (a < ADDR_ROM1) begin
          sel = SEL_ROM0;
        end else if (a < ADDR_CART) begin
          sel = SEL_ROM1;
        end else if (a < ADDR_IO0) begin
          sel = SEL_CART;
        end else if (a < ADDR_IO1) begin
          sel = SEL_IO0;
          fc = fast;
        end else if (a < ADDR_IO2) begin
          sel = SEL_IO1;
        end else if (a < ADDR_SYS) begin
          sel = SEL_IO2;
        end else if (a < ADDR_VECTOR) begin
          sel = SEL_SYS;
          // Set or clear one control bit on a write to the control window
          if (!rd && a >= ADDR_CTRL_WR) begin
            bitm = 16'h0001 << a[4:1];
            ctrl_reg = a[0] ? (ctrl_reg | bitm) : (ctrl_reg & ~bitm);
          end
        end else begin
          sel = SEL_ROM1;
        end
        cyc = fc ? FAST_DIV : SLOW_DIV;
        // Add the rate-switch penalty
        if (fc != rate_fast) begin
          cyc = cyc + (fc ? 2 * (FAST_DIV / 2) : FAST_DIV / 2);
          rate_fast = fc;
        end
        r.device_select = sel;
        r.cpu_cycles = cyc[5:0];
      end
      REQ_VIDEO: begin
        low = 32'(vid_count[3:0]);
        if (!ctrl_reg[12]) begin
          r.video_address = dram_addr(vid_count, ctrl_reg[14:13]);
          r.video_valid = 1'b1;
        end
        if (low + 32'(w.bytes_wanted) < 16) begin
          vid_count = vid_count + {8'h00, w.bytes_wanted};
          got = 32'(w.bytes_wanted);
        end else begin
          got = 16 - low;
          advance_video(got);
        end
        r.bytes_granted = got[7:0];
      end
      REQ_HSYNC: begin
        mode = 32'(ctrl_reg[2:0]);
        advance_video(HS_STEP_BY_MODE[mode]);
        vid_count = vid_count & HS_MASK_BY_MODE[mode];
      end
      REQ_FSYNC: begin
        vid_count = {ctrl_reg[9:3], 9'h000};
        xdiv_cnt = 0;
        ydiv_cnt = 0;
      end
      REQ_LOAD: begin
        ctrl_reg = w.load_value;
      end
      default: begin
      end
    endcase
    r.control_value = ctrl_reg;
    return r;
  endfunction

  // Pick an idle length: mostly short, a few long, with calm stretches of none
  task automatic pick_idle(inout int unsigned calm, output int unsigned len);
    int unsigned roll;
    len = 0;
    if (calm > 0) begin
      calm--;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 3) calm = $urandom_range(20, 80);
      else if (roll < 60) len = 0;
      else if (roll < 88) len = $urandom_range(1, 3);
      else if (roll < 97) len = $urandom_range(4, 12);
      else len = $urandom_range(20, 60);
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Stimulus builders
  function automatic sam_req_t any_word(input logic [2:0] kind);
    sam_req_t w;
    w.req_type = kind;
    w.cpu_address = 16'($urandom);
    w.read_not_write = 1'($urandom);
    w.bytes_wanted = 8'($urandom);
    w.load_value = 16'($urandom);
    return w;
  endfunction

  task automatic queue_word(input sam_req_t w);
    req_backlog.push_back(w);
    kind_tally[w.req_type]++;
    if (w.req_type <= REQ_LOAD) counted_words++;
  endtask

  task automatic queue_cpu(input logic [15:0] addr, input logic rd);
    sam_req_t w;
    w = any_word(REQ_CPU);
    w.cpu_address = addr;
    w.read_not_write = rd;
    queue_word(w);
  endtask

  task automatic queue_fetch(input logic [7:0] n);
    sam_req_t w;
    w = any_word(REQ_VIDEO);
    w.bytes_wanted = n;
    queue_word(w);
  endtask

  task automatic queue_load(input logic [15:0] v);
    sam_req_t w;
    w = any_word(REQ_LOAD);
    w.load_value = v;
    queue_word(w);
  endtask

  task automatic queue_kind(input logic [2:0] kind);
    queue_word(any_word(kind));
  endtask

  // Random CPU access, weighted toward the decode edges and the control window
  task automatic queue_random_cpu();
    int unsigned roll;
    logic [15:0] addr;
    logic        rd;
    roll = $urandom_range(0, 99);
    rd = 1'($urandom);
    if (roll < 20) begin
      addr = 16'($urandom);
    end else if (roll < 40) begin
      addr = 16'($urandom_range(16'h0000, 16'h7FFF));
    end else if (roll < 55) begin
      addr = 16'($urandom_range(16'h8000, 16'hFEFF));
    end else if (roll < 75) begin
      addr = 16'($urandom_range(16'hFF00, 16'hFFFF));
    end else begin
      addr = 16'($urandom_range(16'hFFC0, 16'hFFDF));
      rd = ($urandom_range(0, 4) == 0);
    end
    queue_cpu(addr, rd);
  endtask

  function automatic logic [15:0] random_ctrl();
    logic [15:0] v;
    v = 16'($urandom);
    if ($urandom_range(0, 3) != 0) v[12] = 1'b0;
    return v;
  endfunction

  // One field: sync, then lines of fetches each closed by an hsync
  task automatic queue_frame();
    int unsigned lines;
    int unsigned total;
    int unsigned n;
    if ($urandom_range(0, 1) == 1) queue_load(random_ctrl());
    queue_kind(REQ_FSYNC);
    lines = $urandom_range(1, 16);
    repeat (lines) begin
      total = 0;
      while (total < 32) begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 16);
        queue_fetch(n[7:0]);
        total = total + n + 1;
        if ($urandom_range(0, 9) == 0) queue_random_cpu();
      end
      queue_kind(REQ_HSYNC);
    end
  endtask

  // Driver: present the next word once the current one is taken
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_bus.valid <= 1'b0;
    end else begin
      if (req_bus.valid && req_bus.ready) begin
        result_words_due.push_back(sam_result(req_bus.data));
        words_in++;
      end
      if (!req_bus.valid || req_bus.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          req_bus.valid <= 1'b0;
        end else if (req_backlog.size() > 0) begin
          req_bus.data <= req_backlog.pop_front();
          req_bus.valid <= 1'b1;
          pick_idle(send_calm, send_gap);
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result word with the oldest one due, stall at random
  always @(posedge clk_i) begin : recv
    sam_rsp_t want;
    sam_rsp_t got;
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        words_out++;
        got = rsp_bus.data;
        if (result_words_due.size() == 0) begin
          $error("result word 0x%0h arrived with nothing due", got);
          mismatches++;
        end else begin
          want = result_words_due.pop_front();
          check_field("device_select", 16'(want.device_select), 16'(got.device_select));
          check_field("ram_address", want.ram_address, got.ram_address);
          check_field("is_ram", 16'(want.is_ram), 16'(got.is_ram));
          check_field("cpu_cycles", 16'(want.cpu_cycles), 16'(got.cpu_cycles));
          check_field("video_address", want.video_address, got.video_address);
          check_field("video_valid", 16'(want.video_valid), 16'(got.video_valid));
          check_field("bytes_granted", 16'(want.bytes_granted), 16'(got.bytes_granted));
          check_field("control_value", want.control_value, got.control_value);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
        pick_idle(recv_calm, stall_left);
      end
    end
  end

  // Watchdog: end the run when neither channel moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout after %0d idle cycles", quiet_cycles);
        $display("sam_address_multiplexer regression: fail");
        $finish;
      end
    end
  end

  initial begin
    int unsigned random_start;
    int unsigned total_words;
    int unsigned roll;
    logic [2:0]  k;
    rst_ni = 1'b0;
    req_bus.valid = 1'b0;
    req_bus.data = '0;
    rsp_bus.ready = 1'b0;

    // Directed: reset state, map type 1, rate switches, every region, idle kinds
    queue_cpu(16'h0000, 1'b1);
    queue_cpu(16'hFFFF, 1'b0);
    queue_load(16'hFFFF);
    queue_cpu(16'hFEFF, 1'b1);
    queue_cpu(16'h8000, 1'b0);
    queue_cpu(16'hFF10, 1'b1);
    queue_fetch(8'hFF);
    queue_load(16'h0000);
    queue_cpu(16'hFFD9, 1'b0);
    queue_cpu(16'hFFD8, 1'b0);
    queue_cpu(16'hFFD7, 1'b0);
    queue_cpu(16'hA000, 1'b1);
    queue_cpu(16'hFF30, 1'b1);
    queue_cpu(16'hFF50, 1'b1);
    queue_cpu(16'hFFC5, 1'b1);
    queue_cpu(16'hFFDF, 1'b0);
    queue_cpu(16'hFFC0, 1'b0);
    queue_load(16'h2000);
    queue_cpu(16'h7FFF, 1'b1);
    queue_load(16'h47F8);
    queue_cpu(16'h1234, 1'b0);
    queue_fetch(8'h00);
    queue_kind(REQ_FSYNC);
    queue_fetch(8'd16);
    queue_kind(REQ_HSYNC);
    for (k = KIND_UNUSED_LO; k != 3'd0; k++) queue_kind(k);
    queue_cpu(16'hC000, 1'b1);

    // Random: mostly well-formed fields of fetches, the rest loose items
    random_start = counted_words;
    while (counted_words - random_start < RANDOM_WORDS) begin
      roll = $urandom_range(0, 99);
      if (roll < 35) begin
        queue_frame();
      end else if (roll < 65) begin
        queue_random_cpu();
      end else if (roll < 77) begin
        queue_fetch(8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                    : $urandom_range(0, 20)));
      end else if (roll < 84) begin
        queue_kind(REQ_HSYNC);
      end else if (roll < 89) begin
        queue_kind(REQ_FSYNC);
      end else if (roll < 96) begin
        queue_load(random_ctrl());
      end else begin
        queue_kind(3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI)));
      end
    end
    total_words = req_backlog.size();

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain, then give the output register time to show any stray word
    while (words_out < total_words) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (result_words_due.size() != 0) begin
      $error("%0d result words never arrived", result_words_due.size());
      mismatches++;
    end

    $display("sent %0d words: %0d cpu, %0d fetch, %0d hsync, %0d fsync, %0d load, %0d ignored",
             words_in, kind_tally[REQ_CPU], kind_tally[REQ_VIDEO], kind_tally[REQ_HSYNC],
             kind_tally[REQ_FSYNC], kind_tally[REQ_LOAD],
             kind_tally[5] + kind_tally[6] + kind_tally[7]);
    $display("checked %0d result words, %0d mismatches", words_out, mismatches);
    if (mismatches == 0) begin
      $display("sam_address_multiplexer regression: pass");
    end else begin
      $display("sam_address_multiplexer regression: fail");
    end
    $finish;
  end

endmodule

// ===== sam_address_multiplexer.f =====
rtl/sam_pkg.sv
rtl/sam_req_if.sv
rtl/sam_rsp_if.sv
rtl/sam_cpu_decode.sv
rtl/sam_video_counter.sv
rtl/sam_address_multiplexer.sv
bench/tb_sam_address_multiplexer.sv
